FILE: design/bttr_pkg.sv
package bttr_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int MIN_INTERVALS_DEF = 3;

   localparam int LEVEL_W      = 8;
   localparam int TIME_W       = 16;
   localparam int ELAPSED_W    = 24;
   localparam int RING_W       = 18;
   localparam int TEMPO_W      = 17;
   localparam int WING_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int DIV_STEP_W   = 7;
   localparam int MAP_DVD_W    = TEMPO_W + WING_W + 1;
   localparam int SMOOTH_DVD_W = 21;
   localparam int DECAY_DVD_W  = 22;

   localparam int SMOOTH_DIV  = 10;
   localparam int SMOOTH_BIAS = 5;
   localparam int DECAY_DIV   = 20;
   localparam int DECAY_BIAS  = 10;

   localparam logic [RING_W-1:0]  RING_MAX     = 18'h3FFFF;
   localparam logic [TEMPO_W-1:0] TEMPO_ONE    = 17'd256;
   localparam logic [WING_W-1:0]  WING_DEFAULT = 16'd9421;

   localparam logic [LEVEL_W-1:0]   THRESHOLD_RST = 8'd128;
   localparam logic [ELAPSED_W-1:0] IVL_LOW_RST   = 24'd9830;
   localparam logic [ELAPSED_W-1:0] IVL_HIGH_RST  = 24'd196608;
   localparam logic [ELAPSED_W-1:0] SILENCE_RST   = 24'd327680;
   localparam logic [TEMPO_W-1:0]   FLOOR_RST     = 17'd15360;
   localparam logic [TEMPO_W-1:0]   CEILING_RST   = 17'd46080;
   localparam logic [WING_W-1:0]    WING_LOW_RST  = 16'd6144;
   localparam logic [WING_W-1:0]    WING_HIGH_RST = 16'd24576;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEAT_THRESHOLD  = 3'd0,
      CSR_INTERVAL_LOW    = 3'd1,
      CSR_INTERVAL_HIGH   = 3'd2,
      CSR_SILENCE_TIMEOUT = 3'd3,
      CSR_TEMPO_FLOOR     = 3'd4,
      CSR_TEMPO_CEILING   = 3'd5,
      CSR_WING_RATE_LOW   = 3'd6,
      CSR_WING_RATE_HIGH  = 3'd7
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FRAME,
      S_SUM,
      S_RAW_GO,
      S_RAW_WAIT,
      S_SMOOTH_GO,
      S_SMOOTH_WAIT,
      S_MAPCHK,
      S_MUL,
      S_MAP_GO,
      S_MAP_WAIT,
      S_SILCHK,
      S_DECAY_GO,
      S_DECAY_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_cmd_type;

endpackage

FILE: design/bttr_div.sv
module bttr_div #(
   parameter int DW  = 35,
   parameter int DSW = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bttr_pkg::div_cmd_type cmd,
   input  logic [DW-1:0]        dividend,
   input  logic [DSW-1:0]       divisor,
   output logic [DW-1:0]        quotient,
   output logic                 done
);
   import bttr_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DW-1:0]         work_ff, work_in;
   logic [DSW-1:0]        rem_ff, rem_in;
   logic [DSW-1:0]        dsr_ff, dsr_in;
   logic [DSW:0]          shifted;
   logic [DSW:0]          diff;
   logic                  fits;

   // One quotient bit per cycle; the dividend arrives left-aligned so that the
   // quotient ends up in the low bits of the work register.
   always_comb begin
      shifted = {rem_ff, work_ff[DW-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = cmd.steps;
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[DW-2:0], fits};
         rem_in  = fits ? diff[DSW-1:0] : shifted[DSW-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient = work_ff;
   assign done     = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (cmd.steps != '0 && 32'(cmd.steps) <= DW))
      else $error("divider step count out of range");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cmd.start && step_ff == DIV_STEP_W'(1)) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");

endmodule

FILE: design/beat_tempo_tracker.sv
// An accepted frame passes through the frame, map-check, silence-check and done states;
// a tempo update adds the interval sum, a serial divide for the raw tempo and a smoothing
// divide; interpolation adds a serial multiply and a divide; a silence decay adds a divide.
// One frame is in work at a time, and the next is accepted once the result is registered.
// Synchronous active-high reset loads the register defaults and clears tempo, elapsed time,
// beat edge, slot and count; the interval ring itself is not cleared.
module beat_tempo_tracker #(
   parameter int HISTORY_DEPTH = bttr_pkg::HISTORY_DEPTH_DEF,
   parameter int MIN_INTERVALS = bttr_pkg::MIN_INTERVALS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bttr_pkg::LEVEL_W-1:0]      req_beat_level,
   input  logic [bttr_pkg::TIME_W-1:0]       req_frame_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bttr_pkg::WING_W-1:0]       rsp_wing_rate,
   output logic [bttr_pkg::TEMPO_W-1:0]      rsp_tempo,
   output logic                              rsp_interval_taken,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bttr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bttr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bttr_pkg::*;

   localparam int SLW = $clog2(HISTORY_DEPTH);
   localparam int CW  = $clog2(HISTORY_DEPTH + 1);
   localparam int NW  = $clog2(60 * HISTORY_DEPTH + 1);
   localparam int DVW = NW + ELAPSED_W + 1;
   localparam int SW  = RING_W + CW;
   localparam int DW  = (DVW > MAP_DVD_W) ? DVW : MAP_DVD_W;
   localparam int DSW = (SW > TEMPO_W) ? SW : TEMPO_W;
   localparam int PW  = MAP_DVD_W;
   localparam int MCW = $clog2(TEMPO_W);

   // Configuration registers.
   logic [LEVEL_W-1:0]   thr_ff;
   logic [ELAPSED_W-1:0] ivl_low_ff;
   logic [ELAPSED_W-1:0] ivl_high_ff;
   logic [ELAPSED_W-1:0] silence_ff;
   logic [TEMPO_W-1:0]   floor_ff;
   logic [TEMPO_W-1:0]   ceil_ff;
   logic [WING_W-1:0]    wlo_ff;
   logic [WING_W-1:0]    whi_ff;

   state_type            state_ff, state_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [TIME_W-1:0]    dt_ff, dt_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 was_high_ff, was_high_in;
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic [SLW-1:0]       slot_ff, slot_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 taken_ff, taken_in;
   logic [TEMPO_W-1:0]   raw_ff, raw_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 rdv_ff, rdv_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [MCW-1:0]       mcnt_ff, mcnt_in;
   logic [WING_W-1:0]    wing_ff, wing_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WING_W-1:0]    rsp_wing_ff, rsp_wing_in;
   logic [TEMPO_W-1:0]   rsp_tempo_ff, rsp_tempo_in;
   logic                 rsp_taken_ff, rsp_taken_in;

   logic [RING_W-1:0]    ring_mem [HISTORY_DEPTH];
   logic [RING_W-1:0]    ring_rd_ff;
   logic                 ring_we;
   logic [RING_W-1:0]    ring_wdata;

   logic [ELAPSED_W:0]   el_sum;
   logic [ELAPSED_W-1:0] el_sat;
   logic                 level_high;
   logic                 rise;
   logic                 take;
   logic [CW-1:0]        count_nx;
   logic [NW-1:0]        m60;
   logic [DVW-1:0]       raw_dvd;
   logic [TEMPO_W-1:0]   den;
   logic                 span_neg;
   logic [WING_W-1:0]    span_mag;
   logic [WING_W+1:0]    mac;

   div_cmd_type          div_cmd;
   logic [DW-1:0]        div_dvd;
   logic [DSW-1:0]       div_dsr;
   logic [DW-1:0]        div_q;
   logic                 div_done;

   bttr_div #(
      .DW  (DW),
      .DSW (DSW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (div_q),
      .done     (div_done)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RST;
         ivl_low_ff  <= IVL_LOW_RST;
         ivl_high_ff <= IVL_HIGH_RST;
         silence_ff  <= SILENCE_RST;
         floor_ff    <= FLOOR_RST;
         ceil_ff     <= CEILING_RST;
         wlo_ff      <= WING_LOW_RST;
         whi_ff      <= WING_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BEAT_THRESHOLD:  thr_ff      <= csr_data[LEVEL_W-1:0];
            CSR_INTERVAL_LOW:    ivl_low_ff  <= csr_data[ELAPSED_W-1:0];
            CSR_INTERVAL_HIGH:   ivl_high_ff <= csr_data[ELAPSED_W-1:0];
            CSR_SILENCE_TIMEOUT: silence_ff  <= csr_data[ELAPSED_W-1:0];
            CSR_TEMPO_FLOOR:     floor_ff    <= csr_data[TEMPO_W-1:0];
            CSR_TEMPO_CEILING:   ceil_ff     <= csr_data[TEMPO_W-1:0];
            CSR_WING_RATE_LOW:   wlo_ff      <= csr_data[WING_W-1:0];
            CSR_WING_RATE_HIGH:  whi_ff      <= csr_data[WING_W-1:0];
         endcase
      end
   end

   always_comb begin
      el_sum     = {1'b0, elapsed_ff} + (ELAPSED_W + 1)'(dt_ff);
      el_sat     = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
      level_high = (lvl_ff > thr_ff);
      rise       = level_high && !was_high_ff;
      take       = rise && (el_sat < ivl_high_ff) && (el_sat > ivl_low_ff);
      ring_wdata = (el_sat > ELAPSED_W'(RING_MAX)) ? RING_MAX : el_sat[RING_W-1:0];
      count_nx   = count_ff;
      if (take && (count_ff < CW'(HISTORY_DEPTH))) begin
         count_nx = count_ff + 1'b1;
      end
      m60      = NW'({count_ff, 6'b000000} - {2'b00, count_ff, 2'b00});
      raw_dvd  = DVW'({m60, {ELAPSED_W{1'b0}}}) + DVW'(sum_ff >> 1);
      den      = ceil_ff - floor_ff;
      span_neg = (whi_ff < wlo_ff);
      span_mag = span_neg ? (wlo_ff - whi_ff) : (whi_ff - wlo_ff);
      mac      = {1'b0, prod_ff[PW-1:TEMPO_W]}
               + (prod_ff[0] ? (WING_W + 2)'(span_mag) : '0);
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      dt_in        = dt_ff;
      elapsed_in   = elapsed_ff;
      was_high_in  = was_high_ff;
      tempo_in     = tempo_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      taken_in     = taken_ff;
      raw_in       = raw_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      rdv_in       = 1'b0;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      wing_in      = wing_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_wing_in  = rsp_wing_ff;
      rsp_tempo_in = rsp_tempo_ff;
      rsp_taken_in = rsp_taken_ff;
      ring_we      = 1'b0;
      div_cmd      = '0;
      div_dvd      = '0;
      div_dsr      = '0;
      req_stall    = (state_ff != S_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               lvl_in   = req_beat_level;
               dt_in    = req_frame_time;
               state_in = S_FRAME;
            end
         end
         S_FRAME: begin
            ring_we     = take;
            taken_in    = take;
            count_in    = count_nx;
            was_high_in = level_high;
            elapsed_in  = rise ? '0 : el_sat;
            if (take) begin
               slot_in = (slot_ff == SLW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            end
            sum_in = '0;
            idx_in = '0;
            if (int'(count_nx) >= MIN_INTERVALS) begin
               state_in = S_SUM;
            end else begin
               state_in = S_MAPCHK;
            end
         end
         S_SUM: begin
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + 1'b1;
               rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               sum_in = sum_ff + SW'(ring_rd_ff);
            end
            if (idx_ff == count_ff && !rdv_ff) begin
               state_in = S_RAW_GO;
            end
         end
         S_RAW_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = DIV_STEP_W'(DVW);
            div_dvd       = DW'(raw_dvd) << (DW - DVW);
            div_dsr       = DSW'(sum_ff);
            state_in      = S_RAW_WAIT;
         end
         S_RAW_WAIT: begin
            if (div_done) begin
               raw_in   = (div_q > DW'({TEMPO_W{1'b1}})) ? '1 : div_q[TEMPO_W-1:0];
               state_in = S_SMOOTH_GO;
            end
         end
         S_SMOOTH_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = DIV_STEP_W'(SMOOTH_DVD_W);
            div_dvd       = DW'(SMOOTH_DVD_W'({tempo_ff, 3'b000})
                          + SMOOTH_DVD_W'(tempo_ff)
                          + SMOOTH_DVD_W'(raw_ff)
                          + SMOOTH_DVD_W'(SMOOTH_BIAS)) << (DW - SMOOTH_DVD_W);
            div_dsr       = DSW'(SMOOTH_DIV);
            state_in      = S_SMOOTH_WAIT;
         end
         S_SMOOTH_WAIT: begin
            if (div_done) begin
               tempo_in = div_q[TEMPO_W-1:0];
               state_in = S_MAPCHK;
            end
         end
         S_MAPCHK: begin
            priority if (tempo_ff == '0) begin
               wing_in  = WING_DEFAULT;
               state_in = S_SILCHK;
            end else if (tempo_ff <= floor_ff) begin
               wing_in  = wlo_ff;
               state_in = S_SILCHK;
            end else if (tempo_ff >= ceil_ff) begin
               wing_in  = whi_ff;
               state_in = S_SILCHK;
            end else begin
               prod_in  = PW'(tempo_ff - floor_ff);
               mcnt_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = {mac, prod_ff[TEMPO_W-1:1]};
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MCW'(TEMPO_W - 1)) begin
               state_in = S_MAP_GO;
            end
         end
         S_MAP_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = DIV_STEP_W'(MAP_DVD_W);
            div_dvd       = DW'(prod_ff + MAP_DVD_W'(den >> 1)) << (DW - MAP_DVD_W);
            div_dsr       = DSW'(den);
            state_in      = S_MAP_WAIT;
         end
         S_MAP_WAIT: begin
            if (div_done) begin
               wing_in  = span_neg ? (wlo_ff - div_q[WING_W-1:0])
                                   : (wlo_ff + div_q[WING_W-1:0]);
               state_in = S_SILCHK;
            end
         end
         S_SILCHK: begin
            if (elapsed_ff > silence_ff) begin
               count_in = '0;
               slot_in  = '0;
               state_in = S_DECAY_GO;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DECAY_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = DIV_STEP_W'(DECAY_DVD_W);
            div_dvd       = DW'(DECAY_DVD_W'({tempo_ff, 4'b0000})
                          + DECAY_DVD_W'({tempo_ff, 1'b0})
                          + DECAY_DVD_W'(tempo_ff)
                          + DECAY_DVD_W'(DECAY_BIAS)) << (DW - DECAY_DVD_W);
            div_dsr       = DSW'(DECAY_DIV);
            state_in      = S_DECAY_WAIT;
         end
         S_DECAY_WAIT: begin
            if (div_done) begin
               tempo_in = (div_q[TEMPO_W-1:0] < TEMPO_ONE) ? '0 : div_q[TEMPO_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_wing_in  = wing_ff;
               rsp_tempo_in = tempo_ff;
               rsp_taken_in = taken_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elapsed_ff   <= '0;
         was_high_ff  <= 1'b0;
         tempo_ff     <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         was_high_ff  <= was_high_in;
         tempo_ff     <= tempo_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      dt_ff        <= dt_in;
      taken_ff     <= taken_in;
      raw_ff       <= raw_in;
      sum_ff       <= sum_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      mcnt_ff      <= mcnt_in;
      wing_ff      <= wing_in;
      rsp_wing_ff  <= rsp_wing_in;
      rsp_tempo_ff <= rsp_tempo_in;
      rsp_taken_ff <= rsp_taken_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[idx_ff[SLW-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_wing_rate      = rsp_wing_ff;
   assign rsp_tempo          = rsp_tempo_ff;
   assign rsp_interval_taken = rsp_taken_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HISTORY_DEPTH))
      else $error("interval count beyond history depth");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < HISTORY_DEPTH)
      else $error("write slot beyond history depth");

   a_word_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the finishing state");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_RAW_WAIT || state_ff == S_SMOOTH_WAIT
                    || state_ff == S_MAP_WAIT || state_ff == S_DECAY_WAIT))
      else $error("divider finished while no division was awaited");

endmodule

FILE: dv/beat_tempo_tracker_tb.sv
module beat_tempo_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bttr_pkg::*;

   localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;
   localparam logic [TEMPO_W-1:0]   TEMPO_SAT   = '1;
   localparam int                   SLOT_W      = $clog2(HISTORY_DEPTH_DEF);

   typedef struct packed {
      logic [WING_W-1:0]  wing;
      logic [TEMPO_W-1:0] tempo;
      logic               taken;
   } frame_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [LEVEL_W-1:0]    req_beat_level;
   logic [TIME_W-1:0]     req_frame_time;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [WING_W-1:0]     rsp_wing_rate;
   logic [TEMPO_W-1:0]    rsp_tempo;
   logic                  rsp_interval_taken;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [LEVEL_W-1:0]   cfg_threshold;
   logic [ELAPSED_W-1:0] cfg_ivl_low;
   logic [ELAPSED_W-1:0] cfg_ivl_high;
   logic [ELAPSED_W-1:0] cfg_silence;
   logic [TEMPO_W-1:0]   cfg_floor;
   logic [TEMPO_W-1:0]   cfg_ceiling;
   logic [WING_W-1:0]    cfg_wing_low;
   logic [WING_W-1:0]    cfg_wing_high;

   logic [RING_W-1:0]    ivl_ring [HISTORY_DEPTH_DEF];
   logic [SLOT_W-1:0]    ivl_slot;
   logic [SLOT_W:0]      ivl_count;
   logic [ELAPSED_W-1:0] elapsed_acc;
   logic                 level_was_high;
   logic [TEMPO_W-1:0]   tempo_est;

   frame_result_type frame_results_q[$];
   bit            idle_enable = 1'b1;
   int            mismatches = 0;
   int            frames_sent = 0;
   int            intervals_seen = 0;
   int            decays_seen = 0;
   int            regs_written = 0;

   beat_tempo_tracker u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_beat_level     (req_beat_level),
      .req_frame_time     (req_frame_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_wing_rate      (rsp_wing_rate),
      .rsp_tempo          (rsp_tempo),
      .rsp_interval_taken (rsp_interval_taken),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [WING_W-1:0] map_wing(logic [TEMPO_W-1:0] t);
      longint den, span, num, q, mapped;
      if (t == 0) return WING_DEFAULT;
      if (t <= cfg_floor) return cfg_wing_low;
      if (t >= cfg_ceiling) return cfg_wing_high;
      den = longint'(cfg_ceiling) - longint'(cfg_floor);
      span = longint'(cfg_wing_high) - longint'(cfg_wing_low);
      num = (longint'(t) - longint'(cfg_floor)) * span;
      if (num >= 0) begin
         q = (num + den / 2) / den;
      end else begin
         q = -((-num + den / 2) / den);
      end
      mapped = longint'(cfg_wing_low) + q;
      return mapped[WING_W-1:0];
   endfunction

   function automatic frame_result_type predict_frame(logic [LEVEL_W-1:0] level,
                                                      logic [TIME_W-1:0] dt);
      frame_result_type  res;
      logic [ELAPSED_W:0] acc;
      logic              level_now_high;
      longint unsigned   ring_sum, raw, numer, smooth;
      int unsigned       decayed;
      int                i;
      res.taken = 1'b0;
      acc = elapsed_acc + dt;
      elapsed_acc = acc[ELAPSED_W] ? ELAPSED_SAT : acc[ELAPSED_W-1:0];
      level_now_high = level > cfg_threshold;
      if (level_now_high && !level_was_high) begin
         if (elapsed_acc < cfg_ivl_high && elapsed_acc > cfg_ivl_low) begin
            ivl_ring[ivl_slot] = (elapsed_acc > RING_MAX) ? RING_MAX : elapsed_acc[RING_W-1:0];
            ivl_slot = ivl_slot + 1'b1;
            if (ivl_count < HISTORY_DEPTH_DEF) ivl_count = ivl_count + 1'b1;
            res.taken = 1'b1;
            intervals_seen++;
         end
         elapsed_acc = '0;
      end
      level_was_high = level_now_high;
      if (ivl_count >= MIN_INTERVALS_DEF) begin
         ring_sum = 0;
         for (i = 0; i < ivl_count; i++) ring_sum += ivl_ring[i];
         if (ring_sum == 0) begin
            raw = TEMPO_SAT;
         end else begin
            numer = 64'd60 * (64'd1 << 24) * ivl_count;
            raw = (numer + ring_sum / 2) / ring_sum;
            if (raw > TEMPO_SAT) raw = TEMPO_SAT;
         end
         smooth = (64'd9 * tempo_est + raw + 64'd5) / 64'd10;
         if (smooth > TEMPO_SAT) smooth = TEMPO_SAT;
         tempo_est = smooth[TEMPO_W-1:0];
      end
      res.wing = map_wing(tempo_est);
      if (elapsed_acc > cfg_silence) begin
         decayed = (tempo_est * 32'd19 + 32'd10) / 32'd20;
         tempo_est = (decayed < TEMPO_ONE) ? '0 : decayed[TEMPO_W-1:0];
         ivl_count = '0;
         ivl_slot = '0;
         decays_seen++;
      end
      res.tempo = tempo_est;
      return res;
   endfunction

   function automatic logic [LEVEL_W-1:0] beat_on_level();
      if (cfg_threshold == '1) return '1;
      return LEVEL_W'($urandom_range(cfg_threshold + 1, 255));
   endfunction

   function automatic logic [LEVEL_W-1:0] beat_off_level();
      return LEVEL_W'($urandom_range(0, cfg_threshold));
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = idle_enable && ($urandom_range(0, 99) < 18);
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results_q.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got wing_rate %0d tempo %0d",
                     $time, rsp_wing_rate, rsp_tempo);
            mismatches++;
         end else begin
            want = frame_results_q.pop_front();
            check_field("wing_rate", want.wing, rsp_wing_rate);
            check_field("tempo", want.tempo, rsp_tempo);
            check_field("interval_taken", want.taken, rsp_interval_taken);
         end
      end
   end

   task automatic send_frame(logic [LEVEL_W-1:0] level, logic [TIME_W-1:0] dt);
      while (idle_enable && $urandom_range(0, 99) < 18) @(negedge clock);
      req_valid = 1'b1;
      req_beat_level = level;
      req_frame_time = dt;
      do @(posedge clock); while (req_stall);
      frame_results_q.push_back(predict_frame(level, dt));
      frames_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_results_drained();
      while (frame_results_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int unsigned value);
      wait_results_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BEAT_THRESHOLD:  cfg_threshold = value[LEVEL_W-1:0];
         CSR_INTERVAL_LOW:    cfg_ivl_low = value[ELAPSED_W-1:0];
         CSR_INTERVAL_HIGH:   cfg_ivl_high = value[ELAPSED_W-1:0];
         CSR_SILENCE_TIMEOUT: cfg_silence = value[ELAPSED_W-1:0];
         CSR_TEMPO_FLOOR:     cfg_floor = value[TEMPO_W-1:0];
         CSR_TEMPO_CEILING:   cfg_ceiling = value[TEMPO_W-1:0];
         CSR_WING_RATE_LOW:   cfg_wing_low = value[WING_W-1:0];
         CSR_WING_RATE_HIGH:  cfg_wing_high = value[WING_W-1:0];
         default: ;
      endcase
      regs_written++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_registers(int unsigned thr, int unsigned lo, int unsigned hi,
                                int unsigned sil, int unsigned flo, int unsigned ceil_v,
                                int unsigned wlo, int unsigned whi);
      write_reg(CSR_BEAT_THRESHOLD, thr);
      write_reg(CSR_INTERVAL_LOW, lo);
      write_reg(CSR_INTERVAL_HIGH, hi);
      write_reg(CSR_SILENCE_TIMEOUT, sil);
      write_reg(CSR_TEMPO_FLOOR, flo);
      write_reg(CSR_TEMPO_CEILING, ceil_v);
      write_reg(CSR_WING_RATE_LOW, wlo);
      write_reg(CSR_WING_RATE_HIGH, whi);
   endtask

   // Regular pulse trains with jittered frame times, broken up now and then by
   // random frames and by quiet stretches that can be long enough to reach the timeout.
   task automatic drive_beats(int frames, int dt_lo, int dt_hi);
      int sent, period, width, base_dt, beats, b, k;
      sent = 0;
      while (sent < frames) begin
         base_dt = $urandom_range(dt_lo, dt_hi);
         period = $urandom_range(3, 24);
         width = $urandom_range(1, 3);
         beats = $urandom_range(4, 12);
         for (b = 0; b < beats && sent < frames; b++) begin
            for (k = 0; k < period && sent < frames; k++) begin
               send_frame((k < width) ? beat_on_level() : beat_off_level(),
                          TIME_W'(base_dt + $urandom_range(0, 255)));
               sent++;
            end
         end
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 8)) begin
                  send_frame(LEVEL_W'($urandom_range(0, 255)),
                             TIME_W'($urandom_range(0, 65535)));
                  sent++;
               end
            end
            2: begin
               repeat ($urandom_range(2, 8)) begin
                  send_frame(beat_off_level(), TIME_W'($urandom_range(40000, 65535)));
                  sent++;
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic test_frame_extremes();
      send_frame(8'd0, 16'd0);
      send_frame(8'd255, 16'd65535);
      send_frame(8'd128, 16'd0);
      send_frame(8'd129, 16'd32768);
      send_frame(8'd0, 16'd32768);
      send_frame(8'd200, 16'd32768);
      repeat (6) send_frame(8'd0, 16'd65535);
   endtask

   task automatic test_window_bounds();
      write_reg(CSR_INTERVAL_LOW, 20000);
      write_reg(CSR_INTERVAL_HIGH, 60000);
      send_frame(8'd255, 16'd0);
      send_frame(8'd0, 16'd20000);
      send_frame(8'd255, 16'd0);
      send_frame(8'd0, 16'd20001);
      send_frame(8'd255, 16'd0);
      send_frame(8'd0, 16'd60000);
      send_frame(8'd255, 16'd0);
      send_frame(8'd0, 16'd59999);
      send_frame(8'd255, 16'd0);
   endtask

   task automatic test_default_tempo();
      set_registers(THRESHOLD_RST, IVL_LOW_RST, IVL_HIGH_RST, SILENCE_RST,
                    FLOOR_RST, CEILING_RST, WING_LOW_RST, WING_HIGH_RST);
      drive_beats(100, 1000, 9000);
   endtask

   task automatic test_step_mapping();
      write_reg(CSR_TEMPO_FLOOR, 30000);
      write_reg(CSR_TEMPO_CEILING, 30000);
      drive_beats(120, 1000, 9000);
      write_reg(CSR_TEMPO_FLOOR, 40000);
      write_reg(CSR_TEMPO_CEILING, 20000);
      drive_beats(100, 1000, 9000);
   endtask

   task automatic test_downward_rate();
      set_registers(THRESHOLD_RST, IVL_LOW_RST, IVL_HIGH_RST, SILENCE_RST,
                    FLOOR_RST, CEILING_RST, 60000, 1000);
      drive_beats(150, 1000, 9000);
   endtask

   task automatic test_empty_window();
      write_reg(CSR_INTERVAL_LOW, 100000);
      write_reg(CSR_INTERVAL_HIGH, 100000);
      drive_beats(60, 1000, 9000);
      write_reg(CSR_INTERVAL_LOW, 24'hFFFFFF);
      write_reg(CSR_INTERVAL_HIGH, 0);
      drive_beats(40, 1000, 9000);
   endtask

   task automatic test_threshold_extremes();
      set_registers(0, IVL_LOW_RST, IVL_HIGH_RST, SILENCE_RST,
                    FLOOR_RST, CEILING_RST, WING_LOW_RST, WING_HIGH_RST);
      drive_beats(80, 1000, 9000);
      write_reg(CSR_BEAT_THRESHOLD, 255);
      drive_beats(60, 1000, 9000);
   endtask

   task automatic test_long_intervals();
      set_registers(THRESHOLD_RST, 0, 24'hFFFFFF, 24'hFFFFFF,
                    FLOOR_RST, CEILING_RST, WING_LOW_RST, WING_HIGH_RST);
      drive_beats(150, 20000, 65000);
      repeat (260) send_frame(8'd0, 16'd65535);
      send_frame(8'd255, 16'd65535);
      write_reg(CSR_SILENCE_TIMEOUT, 0);
      drive_beats(60, 1000, 9000);
   endtask

   task automatic test_random_settings();
      int phase;
      int unsigned lo;
      set_registers(0, 0, 0, 0, 0, 1, 0, 0);
      drive_beats(60, 500, 12000);
      set_registers(255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 131071, 131071, 65535, 65535);
      drive_beats(60, 500, 12000);
      for (phase = 0; phase < 5; phase++) begin
         lo = $urandom_range(0, 40000);
         set_registers($urandom_range(0, 255), lo, lo + $urandom_range(0, 300000),
                       $urandom_range(0, 1500000), $urandom_range(0, 60000),
                       $urandom_range(1, 131071), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
         idle_enable = (phase != 2);
         drive_beats(70, 500, 12000);
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat_level = '0;
      req_frame_time = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_BEAT_THRESHOLD;
      csr_data = '0;
      cfg_threshold = THRESHOLD_RST;
      cfg_ivl_low = IVL_LOW_RST;
      cfg_ivl_high = IVL_HIGH_RST;
      cfg_silence = SILENCE_RST;
      cfg_floor = FLOOR_RST;
      cfg_ceiling = CEILING_RST;
      cfg_wing_low = WING_LOW_RST;
      cfg_wing_high = WING_HIGH_RST;
      foreach (ivl_ring[i]) ivl_ring[i] = '0;
      ivl_slot = '0;
      ivl_count = '0;
      elapsed_acc = '0;
      level_was_high = 1'b0;
      tempo_est = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_frame_extremes();
      test_window_bounds();
      test_default_tempo();
      test_step_mapping();
      test_downward_rate();
      test_empty_window();
      test_threshold_extremes();
      test_long_intervals();
      test_random_settings();

      wait_results_drained();
      repeat (200) @(negedge clock);
      $display("Ran %0d frames through %0d register writes, covering step and downward",
               frames_sent, regs_written);
      $display("mappings and empty windows, with %0d intervals recorded and %0d decays.",
               intervals_seen, decays_seen);
      if (mismatches == 0) begin
         $display("beat_tempo_tracker: match");
      end else begin
         $display("beat_tempo_tracker: mismatch");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("beat_tempo_tracker: mismatch");
      $finish;
   end

endmodule
